// ===== rtl/tlop_pkg.sv =====
// shared types and constants for the two-level owner predictor
`default_nettype none
package tlop_pkg;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_BANKS     = 2'd1;

  localparam logic [1:0] CONF_MAX = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [15:0] pc;
    logic [13:0] addr;
    logic [3:0]  local_node;
    logic        sender_is_l2;
    logic [3:0]  sender_node;
  } req_t;

  typedef struct packed {
    logic        answered_predict;
    logic        predicted_c2c;
    logic [15:0] l1_mask;
    logic [15:0] l2_mask;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic calc;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

  function automatic logic [1:0] conf_up(input logic [1:0] c);
    conf_up = (c == CONF_MAX) ? CONF_MAX : c + 2'd1;
  endfunction

  function automatic logic [1:0] conf_down(input logic [1:0] c);
    conf_down = (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tlop_ctrl.sv =====
// controller state machine: clearing pass, request accept, read, compute
`default_nettype none
module tlop_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tlop_pkg::stat_t stat,
  output tlop_pkg::cmd_t     cmd,
  output logic               busy
);
  import tlop_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_READ;
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_READ:  ;
      ST_CALC:  cmd.calc = 1'b1;
      default:  ;
    endcase
  end

  a_read_calc: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_CALC) else $error("read not followed by compute");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == ST_READ) else $error("accepted request lost");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR && !stat.clr_last |=> state == ST_CLEAR) else $error("clear cut short");
endmodule
`default_nettype wire

// ===== rtl/tlop_dp.sv =====
// datapath: both tables, configuration registers, training and mask logic
`default_nettype none
module tlop_dp #(
  parameter int FIRST_ENTRIES  = 1024,
  parameter int SECOND_ENTRIES = 4096,
  parameter int WAYS           = 4,
  parameter int NODES          = 16,
  parameter int HIST_BITS      = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tlop_pkg::cmd_t cmd,
  output tlop_pkg::stat_t    stat,
  input  wire tlop_pkg::req_t req,
  input  wire logic          cfg_valid,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data,
  output logic               done,
  output tlop_pkg::rsp_t     result
);
  import tlop_pkg::*;

  localparam int FA_W   = $clog2(FIRST_ENTRIES);
  localparam int SA_W   = $clog2(SECOND_ENTRIES);
  localparam int PTR_W  = $clog2(NODES);
  localparam int FE_W   = 4 + PTR_W;
  localparam int WAY_W  = 1 + PTR_W + HIST_BITS;
  localparam int SE_W   = 2 + WAYS * WAY_W;
  localparam int MAX_E  = (FIRST_ENTRIES > SECOND_ENTRIES) ? FIRST_ENTRIES : SECOND_ENTRIES;
  localparam int CLR_W  = $clog2(MAX_E);
  localparam int WIX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [HIST_BITS-1:0] HIST_MAX = '1;

  logic [FE_W-1:0] first_mem  [FIRST_ENTRIES];
  logic [SE_W-1:0] second_mem [SECOND_ENTRIES];
  logic [FE_W-1:0] first_rd;
  logic [SE_W-1:0] second_rd;

  req_t       rq;
  logic [1:0] thr;
  logic [4:0] banks;
  logic [CLR_W-1:0] clr_cnt;

  logic [FA_W-1:0] i1;
  logic [SA_W-1:0] i2;
  assign i1 = FA_W'(32'(rq.pc[15:6]) % FIRST_ENTRIES);
  assign i2 = SA_W'(32'(rq.pc[15:4] ^ rq.addr[13:2]) % SECOND_ENTRIES);

  assign stat.clr_last = (clr_cnt == CLR_W'(MAX_E - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= 2'd2;
      banks <= 5'd4;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_THRESHOLD) thr   <= cfg_data[1:0];
      if (cfg_index == CFG_BANKS)     banks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr && !stat.clr_last) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rq <= req;
  end

  // first-table fields
  logic [1:0]       f_c2c, f_node;
  logic [PTR_W-1:0] f_ptr;
  assign {f_c2c, f_node, f_ptr} = first_rd;

  logic [1:0]       s_conf;
  logic             w_val  [WAYS];
  logic [PTR_W-1:0] w_ptr  [WAYS];
  logic [HIST_BITS-1:0] w_hist [WAYS];
  always_comb begin
    s_conf = second_rd[SE_W-1 -: 2];
    for (int w = 0; w < WAYS; w++) begin
      {w_val[w], w_ptr[w], w_hist[w]} = second_rd[w*WAY_W +: WAY_W];
    end
  end

  function automatic logic [15:0] node_bit(input logic [PTR_W-1:0] n);
    logic [15:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) m[i] = (8'(n) == 8'(i));
    return m;
  endfunction

  logic [7:0] sender8;
  assign sender8 = 8'(rq.sender_node);

  // prediction
  rsp_t pred;
  always_comb begin
    pred = '0;
    pred.answered_predict = 1'b1;
    pred.l1_mask = 16'(1) << rq.local_node;
    for (int i = 0; i < 16; i++) pred.l2_mask[i] = (5'(i) < banks);
    if (f_c2c >= thr) begin
      pred.predicted_c2c = 1'b1;
      if (f_node >= thr) pred.l1_mask = pred.l1_mask | node_bit(f_ptr);
      if (s_conf >= thr) begin
        for (int w = 0; w < WAYS; w++) begin
          if (w_val[w] && w_ptr[w] != f_ptr) pred.l1_mask = pred.l1_mask | node_bit(w_ptr[w]);
        end
      end
    end
  end

  // first-table training
  logic [1:0]       nf_c2c, nf_node;
  logic [PTR_W-1:0] nf_ptr;
  always_comb begin
    nf_node = f_node;
    nf_ptr  = f_ptr;
    if (rq.sender_is_l2) begin
      nf_c2c = conf_down(f_c2c);
    end else begin
      nf_c2c  = conf_up(f_c2c);
      nf_node = (8'(f_ptr) == sender8) ? conf_up(f_node) : conf_down(f_node);
      if (nf_node < thr) nf_ptr = PTR_W'(rq.sender_node);
    end
  end

  // second-table training
  logic             hit;
  logic [WIX_W-1:0] victim;
  logic [SE_W-1:0]  s_new;
  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (w_val[w] && 8'(w_ptr[w]) == sender8) hit = 1'b1;
    victim = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (w_val[victim] && !w_val[w]) victim = WIX_W'(w);
      else if (w_val[victim] && w_val[w] && w_hist[w] > w_hist[victim]) victim = WIX_W'(w);
    end
    s_new = second_rd;
    if (hit) begin
      s_new[SE_W-1 -: 2] = conf_up(s_conf);
      for (int w = 0; w < WAYS; w++) begin
        if (w_val[w]) begin
          if (8'(w_ptr[w]) == sender8)
            s_new[w*WAY_W +: HIST_BITS] = '0;
          else if (w_hist[w] != HIST_MAX)
            s_new[w*WAY_W +: HIST_BITS] = w_hist[w] + 1'b1;
        end
      end
    end else begin
      s_new[SE_W-1 -: 2] = conf_down(s_conf);
      for (int w = 0; w < WAYS; w++) begin
        if (WIX_W'(w) == victim)
          s_new[w*WAY_W +: WAY_W] = {1'b1, PTR_W'(rq.sender_node), {HIST_BITS{1'b0}}};
      end
    end
  end

  logic upd;
  assign upd = cmd.calc && (rq.opcode == OP_UPDATE);

  always_ff @(posedge clk) begin
    if (cmd.clr && 32'(clr_cnt) < FIRST_ENTRIES)
      first_mem[FA_W'(clr_cnt)] <= '0;
    else if (upd)
      first_mem[i1] <= {nf_c2c, nf_node, nf_ptr};
    first_rd <= first_mem[i1];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && 32'(clr_cnt) < SECOND_ENTRIES)
      second_mem[SA_W'(clr_cnt)] <= {2'd1, {(SE_W-2){1'b0}}};
    else if (upd && !rq.sender_is_l2)
      second_mem[i2] <= s_new;
    second_rd <= second_mem[i2];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.calc;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) result <= (rq.opcode == OP_PREDICT) ? pred : '0;
  end

  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.calc)) else $error("result strobe without compute");
  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !done && !cmd.calc) else $error("request during clearing pass");
  a_victim: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |-> 32'(victim) < WAYS) else $error("victim way out of range");
endmodule
`default_nettype wire

// ===== rtl/two_level_owner_predictor.sv =====
// top level: two-level coherence owner predictor
// a request is accepted when start is high and busy low; its result strobes on done,
// one result per request, and busy holds off a new request until the last is through
// (a table read state, then a compute and write-back state; single-port tables)
// after reset, busy stays high while both tables are swept to their reset contents;
// configuration writes are taken at any time
`default_nettype none
module two_level_owner_predictor #(
  parameter int FIRST_ENTRIES  = 1024,
  parameter int SECOND_ENTRIES = 4096,
  parameter int WAYS           = 4,
  parameter int NODES          = 16,
  parameter int HIST_BITS      = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tlop_pkg::req_t req,
  output logic               done,
  output tlop_pkg::rsp_t     result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data
);
  import tlop_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tlop_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tlop_dp #(
    .FIRST_ENTRIES  (FIRST_ENTRIES),
    .SECOND_ENTRIES (SECOND_ENTRIES),
    .WAYS           (WAYS),
    .NODES          (NODES),
    .HIST_BITS      (HIST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );
endmodule
`default_nettype wire

// ===== verif/two_level_owner_predictor_tb.sv =====
// testbench for the two-level owner predictor: directed and random requests, scoreboard check
`default_nettype none
module two_level_owner_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlop_pkg::*;

  localparam int FIRST_N  = 1024;
  localparam int SECOND_N = 4096;
  localparam int NWAYS    = 4;
  localparam int HMAX     = 15;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  two_level_owner_predictor dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the tables
  logic [1:0] ft_c2c [FIRST_N];
  logic [1:0] ft_nconf [FIRST_N];
  logic [3:0] ft_ptr [FIRST_N];
  logic [1:0] st_conf [SECOND_N];
  logic       st_valid [SECOND_N][NWAYS];
  logic [3:0] st_ptr [SECOND_N][NWAYS];
  logic [3:0] st_hist [SECOND_N][NWAYS];
  logic [1:0] thresh = 2'd2;
  logic [4:0] banks = 5'd4;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   send_idle_pct = 0;
  int   errors = 0;
  int   accepted = 0;
  int   n_predict = 0;
  int   n_update = 0;
  int   stall_cycles = 0;
  logic busy_at_edge = 1'b1;

  function automatic logic [1:0] sat_up(logic [1:0] c);
    return (c == 2'd3) ? 2'd3 : c + 2'd1;
  endfunction

  function automatic logic [1:0] sat_down(logic [1:0] c);
    return (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

  function automatic rsp_t predict_and_train(req_t r);
    rsp_t o;
    int   i1, i2, victim;
    logic hit;
    logic [4:0] nb;
    o = '0;
    i1 = int'(r.pc[15:6]) % FIRST_N;
    i2 = int'(r.pc[15:4] ^ r.addr[13:2]) % SECOND_N;
    if (r.opcode == OP_PREDICT) begin
      nb = (banks > 5'd16) ? 5'd16 : banks;
      o.answered_predict = 1'b1;
      o.l1_mask = 16'(1) << r.local_node;
      o.l2_mask = 16'((32'd1 << nb) - 32'd1);
      if (ft_c2c[i1] >= thresh) begin
        o.predicted_c2c = 1'b1;
        if (ft_nconf[i1] >= thresh) o.l1_mask |= 16'(1) << ft_ptr[i1];
        if (st_conf[i2] >= thresh)
          for (int w = 0; w < NWAYS; w++)
            if (st_valid[i2][w] && st_ptr[i2][w] != ft_ptr[i1])
              o.l1_mask |= 16'(1) << st_ptr[i2][w];
      end
      return o;
    end
    if (r.sender_is_l2) begin
      ft_c2c[i1] = sat_down(ft_c2c[i1]);
      return o;
    end
    ft_c2c[i1] = sat_up(ft_c2c[i1]);
    if (ft_ptr[i1] == r.sender_node) ft_nconf[i1] = sat_up(ft_nconf[i1]);
    else ft_nconf[i1] = sat_down(ft_nconf[i1]);
    if (ft_nconf[i1] < thresh) ft_ptr[i1] = r.sender_node;
    hit = 1'b0;
    for (int w = 0; w < NWAYS; w++)
      if (st_valid[i2][w] && st_ptr[i2][w] == r.sender_node) hit = 1'b1;
    if (hit) begin
      st_conf[i2] = sat_up(st_conf[i2]);
      for (int w = 0; w < NWAYS; w++)
        if (st_valid[i2][w]) begin
          if (st_ptr[i2][w] == r.sender_node) st_hist[i2][w] = '0;
          else if (st_hist[i2][w] < HMAX) st_hist[i2][w] = st_hist[i2][w] + 4'd1;
        end
    end else begin
      st_conf[i2] = sat_down(st_conf[i2]);
      victim = 0;
      for (int w = 1; w < NWAYS; w++)
        if (st_valid[i2][victim] && !st_valid[i2][w]) victim = w;
        else if (st_valid[i2][victim] && st_valid[i2][w] &&
                 st_hist[i2][w] > st_hist[i2][victim]) victim = w;
      st_ptr[i2][victim] = r.sender_node;
      st_hist[i2][victim] = '0;
      st_valid[i2][victim] = 1'b1;
    end
    return o;
  endfunction

  // driver: one request per accept, idle gaps at the configured rate
  always @(negedge clk) begin
    if (!rst) begin
      if (pending_reqs.size() > 0 && !(start && busy_at_edge)
          && $urandom_range(99) >= send_idle_pct) begin
        req <= pending_reqs[0];
        start <= 1'b1;
      end else if (!(start && busy_at_edge)) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: takes requests and results at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      busy_at_edge <= 1'b1;
    end else begin
      busy_at_edge <= busy;
      if (start && !busy) begin
        expected_rsps.push_back(predict_and_train(req));
        if (req.opcode == OP_PREDICT) n_predict++;
        else n_update++;
        void'(pending_reqs.pop_front());
        accepted++;
      end
      if (done) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (result.answered_predict !== e.answered_predict) begin
            $error("answered_predict exp %0d got %0d", e.answered_predict,
                   result.answered_predict);
            errors++;
          end
          if (result.predicted_c2c !== e.predicted_c2c) begin
            $error("predicted_c2c exp %0d got %0d", e.predicted_c2c, result.predicted_c2c);
            errors++;
          end
          if (result.l1_mask !== e.l1_mask) begin
            $error("l1_mask exp %h got %h", e.l1_mask, result.l1_mask);
            errors++;
          end
          if (result.l2_mask !== e.l2_mask) begin
            $error("l2_mask exp %h got %h", e.l2_mask, result.l2_mask);
            errors++;
          end
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (stall_cycles > STALL_LIMIT &&
        (pending_reqs.size() > 0 || expected_rsps.size() > 0 || cfg_valid)) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_THRESHOLD) thresh = val[1:0];
    else if (idx == CFG_BANKS) banks = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t mk(logic op, logic [15:0] pc, logic [13:0] a, logic [3:0] ln,
                              logic l2, logic [3:0] sn);
    req_t r;
    r.opcode = op; r.pc = pc; r.addr = a; r.local_node = ln;
    r.sender_is_l2 = l2; r.sender_node = sn;
    return r;
  endfunction

  // hot pcs and addresses so tables train deep; the rest spread wide
  function automatic req_t rand_req();
    req_t r;
    r = req_t'(40'({$urandom, $urandom}));
    if ($urandom_range(99) < 80) begin
      r.pc = 16'($urandom_range(7)) << 6 | 16'($urandom_range(63));
      r.addr = 14'($urandom_range(15)) << 2 | 14'($urandom_range(3));
      r.pc[15] = 1'($urandom_range(1));
      r.sender_node = 4'($urandom_range(5));
      r.sender_is_l2 = ($urandom_range(99) < 15);
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i < FIRST_N; i++) begin
      ft_c2c[i] = '0; ft_nconf[i] = '0; ft_ptr[i] = '0;
    end
    for (int i = 0; i < SECOND_N; i++) begin
      st_conf[i] = 2'd1;
      for (int w = 0; w < NWAYS; w++) begin
        st_valid[i][w] = 1'b0; st_ptr[i][w] = '0; st_hist[i][w] = '0;
      end
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, both operations, l2 and l1 suppliers, repeated trains
    pending_reqs.push_back(mk(OP_PREDICT, 16'h0000, 14'h0000, 4'h0, 1'b0, 4'h0));
    pending_reqs.push_back(mk(OP_PREDICT, 16'hffff, 14'h3fff, 4'hf, 1'b1, 4'hf));
    pending_reqs.push_back(mk(OP_UPDATE, 16'hffff, 14'h3fff, 4'hf, 1'b1, 4'hf));
    for (int k = 0; k < 6; k++)
      pending_reqs.push_back(mk(OP_UPDATE, 16'h0040, 14'h0004, 4'h1, 1'b0, 4'(k % 5 + 3)));
    for (int k = 0; k < 4; k++)
      pending_reqs.push_back(mk(OP_UPDATE, 16'h0040, 14'h0004, 4'h1, 1'b0, 4'h9));
    pending_reqs.push_back(mk(OP_PREDICT, 16'h0040, 14'h0004, 4'h2, 1'b0, 4'h0));
    pending_reqs.push_back(mk(OP_UPDATE, 16'h0040, 14'h0004, 4'h1, 1'b1, 4'h0));
    pending_reqs.push_back(mk(OP_PREDICT, 16'h0040, 14'h0004, 4'h2, 1'b0, 4'h0));
    pending_reqs.push_back(mk(OP_UPDATE, 16'hffc0, 14'h3ffc, 4'h0, 1'b0, 4'hf));
    pending_reqs.push_back(mk(OP_PREDICT, 16'hffc0, 14'h3ffc, 4'h0, 1'b0, 4'h0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_THRESHOLD, 5'(ph % 4));
      write_reg(CFG_BANKS, (ph == 0) ? 5'd0 : (ph == 1) ? 5'd16 : (ph == 2) ? 5'd31
                           : 5'($urandom_range(31)));
      send_idle_pct = (ph < 3) ? 36 : (ph < 6) ? 76 : 0;
      for (int k = 0; k < 200; k++) pending_reqs.push_back(rand_req());
      drain();
    end

    $display("%0d requests taken: %0d predictions, %0d training updates", accepted,
             n_predict, n_update);
    $display("threshold swept 0..3, bank count 0, 16, 31 and random");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
